FILE: hw/rtl/vfv_pkg.sv
// ----------------------------------------------------------------------------
// vfv_pkg: shared types and constants of the vortex force pipeline
// Widths of the intermediate values up to the root search, register index
// codes and the structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package vfv_pkg;

   // field widths
   localparam int CoordW  = 32;              // Q16.16 position, center, force
   localparam int AxisW   = 16;              // Q1.14 axis
   localparam int MagW    = 32;              // Q16.16 magnitude
   localparam int NumComp = 3;

   // cross product datapath
   localparam int DiffW  = CoordW + 1;       // center - position
   localparam int ProdW  = DiffW + AxisW;    // one term of the cross product
   localparam int CrossW = ProdW + 1;        // difference of two terms
   localparam int AbsW   = CrossW - 1;       // |c| stays below 2^49

   // squares, split in halves to keep each multiplier small
   localparam int LoW  = 25;
   localparam int HiW  = AbsW - LoW;
   localparam int HhW  = 2 * HiW;
   localparam int HlW  = HiW + LoW;
   localparam int LlW  = 2 * LoW;
   localparam int SqW  = 98;                 // sum of three squares < 2^98

   // unit vector root search
   localparam int UnitW  = 16;               // unit magnitude in [0, 32768]
   localparam int TgtSh  = 30;               // c^2 is compared at 2^30 scale
   localparam int RemW   = 131;              // q^2 * S stays below 2^131
   localparam int FracSh = 15;               // Q1.15 unit vector

   // register file
   localparam int CsrIdxW = 3;
   localparam logic signed [AxisW-1:0] AxisYReset    = 16'sd16384;
   localparam logic signed [MagW-1:0]  MagnitudeReset = 32'sd65536;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_CENTER_X  = 3'd0,
      CSR_CENTER_Y  = 3'd1,
      CSR_CENTER_Z  = 3'd2,
      CSR_AXIS_X    = 3'd3,
      CSR_AXIS_Y    = 3'd4,
      CSR_AXIS_Z    = 3'd5,
      CSR_MAGNITUDE = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [AxisW-1:0] x;
      logic signed [AxisW-1:0] y;
      logic signed [AxisW-1:0] z;
   } axis_type;

   // cross product as sign and magnitude
   typedef struct packed {
      logic [NumComp-1:0][AbsW-1:0] abs_val;
      logic [NumComp-1:0]           neg;
      logic                         zero;
   } cross_type;

   // state of the bitwise root search
   typedef struct packed {
      logic [NumComp-1:0][RemW-1:0]  rem;    // c^2 * 2^30 - q^2 * S
      logic [NumComp-1:0][RemW-1:0]  prod;   // q * S
      logic [NumComp-1:0][UnitW-1:0] unit;   // q
      logic [SqW-1:0]                sumsq;  // S
      logic [NumComp-1:0]            neg;
      logic                          zero;
   } root_type;

   typedef struct packed {
      logic [NumComp-1:0][UnitW-1:0] unit;
      logic [NumComp-1:0]            neg;
      logic                          zero;
   } unit_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
      logic                     on_axis;
   } force_type;

endpackage

FILE: hw/rtl/vfv_if.sv
// ----------------------------------------------------------------------------
// vfv_if: channel interfaces of the vortex force block
// Particle request, force response and register write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface vfv_req_if;
   import vfv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] pos_x;
   logic signed [CoordW-1:0] pos_y;
   logic signed [CoordW-1:0] pos_z;
   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface vfv_rsp_if;
   import vfv_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [CoordW-1:0] force_x;
   logic signed [CoordW-1:0] force_y;
   logic signed [CoordW-1:0] force_z;
   logic                     on_axis;
   modport source (output valid, force_x, force_y, force_z, on_axis, input ready);
   modport sink   (input valid, force_x, force_y, force_z, on_axis, output ready);
endinterface

interface vfv_csr_if;
   import vfv_pkg::*;
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [CoordW-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/vfv_cross.sv
// ----------------------------------------------------------------------------
// vfv_cross: offset and cross product section
// Four stages: center minus position, the six axis products, the cross
// product, and its conversion to sign and magnitude with the zero test.
// ----------------------------------------------------------------------------
module vfv_cross (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  vfv_pkg::vec_type    in_pos,
   input  vfv_pkg::vec_type    center,
   input  vfv_pkg::axis_type   axis,
   output logic                out_valid,
   input  logic                out_ready,
   output vfv_pkg::cross_type  out_data
);
   import vfv_pkg::*;

   localparam int Stages  = 4;
   localparam int NumProd = 2 * NumComp;

   logic [Stages-1:0] valid_ff, valid_in, stage_rdy;

   logic signed [DiffW-1:0]  diff_in  [NumComp];
   logic signed [DiffW-1:0]  diff_ff  [NumComp];
   logic signed [ProdW-1:0]  prod_in  [NumProd];
   logic signed [ProdW-1:0]  prod_ff  [NumProd];
   logic signed [CrossW-1:0] cross_in [NumComp];
   logic signed [CrossW-1:0] cross_ff [NumComp];
   logic signed [CrossW-1:0] cross_neg [NumComp];
   cross_type                out_in, out_ff;

   // stage handshake: a stage moves when it is empty or its successor moves
   always_comb begin
      stage_rdy[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in = valid_ff;
      if (stage_rdy[0]) valid_in[0] = in_valid;
      for (int k = 1; k < Stages; k++) begin
         if (stage_rdy[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // offset from particle to center
   always_comb begin
      diff_in[0] = DiffW'(center.x) - DiffW'(in_pos.x);
      diff_in[1] = DiffW'(center.y) - DiffW'(in_pos.y);
      diff_in[2] = DiffW'(center.z) - DiffW'(in_pos.z);
   end

   // cross product terms, paired as (plus, minus) per component
   always_comb begin
      prod_in[0] = ProdW'(diff_ff[1]) * ProdW'(axis.z);
      prod_in[1] = ProdW'(diff_ff[2]) * ProdW'(axis.y);
      prod_in[2] = ProdW'(diff_ff[2]) * ProdW'(axis.x);
      prod_in[3] = ProdW'(diff_ff[0]) * ProdW'(axis.z);
      prod_in[4] = ProdW'(diff_ff[0]) * ProdW'(axis.y);
      prod_in[5] = ProdW'(diff_ff[1]) * ProdW'(axis.x);
   end

   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         cross_in[i] = CrossW'(prod_ff[2*i]) - CrossW'(prod_ff[2*i+1]);
      end
   end

   // sign and magnitude; |c| <= 2^48 so the negation never wraps
   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         cross_neg[i]      = -cross_ff[i];
         out_in.neg[i]     = cross_ff[i][CrossW-1];
         out_in.abs_val[i] = cross_ff[i][CrossW-1] ? AbsW'(cross_neg[i])
                                                   : AbsW'(cross_ff[i]);
      end
      out_in.zero = (cross_ff[0] == '0) && (cross_ff[1] == '0) && (cross_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) diff_ff  <= diff_in;
      if (stage_rdy[1]) prod_ff  <= prod_in;
      if (stage_rdy[2]) cross_ff <= cross_in;
      if (stage_rdy[3]) out_ff   <= out_in;
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

endmodule

FILE: hw/rtl/vfv_square.sv
// ----------------------------------------------------------------------------
// vfv_square: squared length section
// Squares each cross product component from half-width partial products,
// sums them to S and scales each square by 2^30 as the root search target.
// ----------------------------------------------------------------------------
module vfv_square (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  vfv_pkg::cross_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output vfv_pkg::root_type  out_data
);
   import vfv_pkg::*;

   localparam int Stages = 3;

   logic [Stages-1:0] valid_ff, valid_in, stage_rdy;

   logic [HhW-1:0]     hh_in [NumComp];
   logic [HhW-1:0]     hh_ff [NumComp];
   logic [HlW-1:0]     hl_in [NumComp];
   logic [HlW-1:0]     hl_ff [NumComp];
   logic [LlW-1:0]     ll_in [NumComp];
   logic [LlW-1:0]     ll_ff [NumComp];
   logic [SqW-1:0]     sq_in [NumComp];
   logic [SqW-1:0]     sq_ff [NumComp];
   logic [NumComp-1:0] neg1_ff, neg2_ff;
   logic               zero1_ff, zero2_ff;
   root_type           out_in, out_ff;

   // stage handshake
   always_comb begin
      stage_rdy[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in = valid_ff;
      if (stage_rdy[0]) valid_in[0] = in_valid;
      for (int k = 1; k < Stages; k++) begin
         if (stage_rdy[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // partial products of the split magnitude
   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         hh_in[i] = HhW'(in_data.abs_val[i][AbsW-1:LoW]) * HhW'(in_data.abs_val[i][AbsW-1:LoW]);
         hl_in[i] = HlW'(in_data.abs_val[i][AbsW-1:LoW]) * HlW'(in_data.abs_val[i][LoW-1:0]);
         ll_in[i] = LlW'(in_data.abs_val[i][LoW-1:0]) * LlW'(in_data.abs_val[i][LoW-1:0]);
      end
   end

   // square = hh*2^50 + 2*hl*2^25 + ll
   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         sq_in[i] = (SqW'(hh_ff[i]) << LlW) + (SqW'(hl_ff[i]) << (LoW + 1)) + SqW'(ll_ff[i]);
      end
   end

   // root search start: remainder is the target, quotient and q*S zero
   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         out_in.rem[i]  = RemW'(sq_ff[i]) << TgtSh;
         out_in.prod[i] = '0;
         out_in.unit[i] = '0;
      end
      out_in.sumsq = sq_ff[0] + sq_ff[1] + sq_ff[2];
      out_in.neg   = neg2_ff;
      out_in.zero  = zero2_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         ll_ff    <= ll_in;
         neg1_ff  <= in_data.neg;
         zero1_ff <= in_data.zero;
      end
      if (stage_rdy[1]) begin
         sq_ff    <= sq_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
      end
      if (stage_rdy[2]) out_ff <= out_in;
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

endmodule

FILE: hw/rtl/vfv_root.sv
// ----------------------------------------------------------------------------
// vfv_root: unit vector root search
// One stage per bit of the unit magnitude, most significant first. Each
// stage finds the largest q with q^2 * S <= c^2 * 2^30 one bit further,
// keeping the remainder and q*S so that only shifts and adds are needed.
// ----------------------------------------------------------------------------
module vfv_root (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vfv_pkg::root_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vfv_pkg::unit_type out_data
);
   import vfv_pkg::*;

   localparam int Stages = UnitW;

   logic [Stages-1:0] valid_ff, valid_in, stage_rdy;
   root_type          stage_in [Stages];
   root_type          stage_ff [Stages];

   // stage handshake
   always_comb begin
      stage_rdy[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in = valid_ff;
      if (stage_rdy[0]) valid_in[0] = in_valid;
      for (int k = 1; k < Stages; k++) begin
         if (stage_rdy[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // one trial bit per stage
   for (genvar k = 0; k < Stages; k++) begin : g_bit
      localparam int Bit = UnitW - 1 - k;
      root_type        src, nxt;
      logic [RemW-1:0] dec [NumComp];

      if (k == 0) begin : g_first
         assign src = in_data;
      end else begin : g_next
         assign src = stage_ff[k-1];
      end

      // (q + 2^b)^2 S - q^2 S = qS * 2^(b+1) + S * 2^(2b)
      always_comb begin
         nxt = src;
         for (int i = 0; i < NumComp; i++) begin
            dec[i] = (src.prod[i] << (Bit + 1)) + (RemW'(src.sumsq) << (2 * Bit));
            if (src.rem[i] >= dec[i]) begin
               nxt.rem[i]  = src.rem[i] - dec[i];
               nxt.unit[i] = src.unit[i] | (UnitW'(1) << Bit);
               nxt.prod[i] = src.prod[i] + (RemW'(src.sumsq) << Bit);
            end
         end
      end

      assign stage_in[k] = nxt;
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < Stages; k++) begin
         if (stage_rdy[k]) stage_ff[k] <= stage_in[k];
      end
   end

   assign in_ready       = stage_rdy[0];
   assign out_valid      = valid_ff[Stages-1];
   assign out_data.unit  = stage_ff[Stages-1].unit;
   assign out_data.neg   = stage_ff[Stages-1].neg;
   assign out_data.zero  = stage_ff[Stages-1].zero;

endmodule

FILE: hw/rtl/vfv_scale.sv
// ----------------------------------------------------------------------------
// vfv_scale: magnitude scaling and output register
// Multiplies the magnitude by each unit component, truncates toward zero
// from Q1.15, applies the sign and saturates to the 32-bit force range.
// ----------------------------------------------------------------------------
module vfv_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  vfv_pkg::unit_type       in_data,
   input  logic signed [vfv_pkg::MagW-1:0] magnitude,
   output logic                    out_valid,
   input  logic                    out_ready,
   output vfv_pkg::force_type      out_data
);
   import vfv_pkg::*;

   localparam int Stages = 2;
   localparam int PrdW   = MagW + UnitW;
   localparam int FabsW  = PrdW - FracSh;

   logic [Stages-1:0] valid_ff, valid_in, stage_rdy;

   logic [MagW-1:0]    mag_abs;
   logic [PrdW-1:0]    mprod_in [NumComp];
   logic [PrdW-1:0]    mprod_ff [NumComp];
   logic [NumComp-1:0] sign_in, sign_ff;
   logic               zero_ff;
   logic [FabsW-1:0]   fabs [NumComp];
   logic [FabsW-1:0]   fneg [NumComp];
   logic [MagW-1:0]    fval [NumComp];
   force_type          out_in, out_ff;

   // stage handshake
   always_comb begin
      stage_rdy[Stages-1] = !valid_ff[Stages-1] || out_ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in = valid_ff;
      if (stage_rdy[0]) valid_in[0] = in_valid;
      for (int k = 1; k < Stages; k++) begin
         if (stage_rdy[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // unsigned product |magnitude| * q, sign kept aside
   always_comb begin
      mag_abs = magnitude[MagW-1] ? (MagW'(0) - magnitude) : magnitude;
      for (int i = 0; i < NumComp; i++) begin
         mprod_in[i] = PrdW'(mag_abs) * PrdW'(in_data.unit[i]);
         sign_in[i]  = magnitude[MagW-1] ^ in_data.neg[i];
      end
   end

   // truncate toward zero, sign, saturate (only +2^31 can overflow)
   always_comb begin
      for (int i = 0; i < NumComp; i++) begin
         fabs[i] = mprod_ff[i][PrdW-1:FracSh];
         fneg[i] = ~fabs[i] + FabsW'(1);
         if (sign_ff[i]) begin
            fval[i] = fneg[i][MagW-1:0];
         end else if (fabs[i][FabsW-1:MagW-1] != '0) begin
            fval[i] = {1'b0, {(MagW-1){1'b1}}};
         end else begin
            fval[i] = fabs[i][MagW-1:0];
         end
         if (zero_ff) fval[i] = '0;
      end
      out_in.x       = fval[0];
      out_in.y       = fval[1];
      out_in.z       = fval[2];
      out_in.on_axis = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         mprod_ff <= mprod_in;
         sign_ff  <= sign_in;
         zero_ff  <= in_data.zero;
      end
      if (stage_rdy[1]) out_ff <= out_in;
   end

   assign in_ready  = stage_rdy[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

endmodule

FILE: hw/rtl/vortex_force_vector.sv
// ----------------------------------------------------------------------------
// vortex_force_vector: force of a vortex on one particle
// Register file and the four pipeline sections from position to force.
// ----------------------------------------------------------------------------
// The block accepts one particle position per cycle unless stalled. It has
// 4 stages for offset and cross product, 3 for the squared length, 16 for
// the unit vector (one stage per quotient bit of the Q1.15 root search)
// and 2 for scaling. Every stage holds its own valid bit, so a stalled
// response only stops items behind it and empty stages keep filling.
// Register writes take effect at once and are meant for times when no
// transaction is in flight. Force components are exact to truncation
// toward zero; a particle on the axis gives zero force with on_axis set.
// ----------------------------------------------------------------------------
module vortex_force_vector (
   input logic       clock,
   input logic       reset,
   vfv_req_if.sink   req_ch,
   vfv_rsp_if.source rsp_ch,
   vfv_csr_if.sink   csr_ch
);
   import vfv_pkg::*;

   vec_type                center_ff;
   axis_type               axis_ff;
   logic signed [MagW-1:0] magnitude_ff;
   vec_type                req_pos;

   logic      cross_valid, cross_ready;
   cross_type cross_data;
   logic      sq_valid, sq_ready;
   root_type  sq_data;
   logic      unit_valid, unit_ready;
   unit_type  unit_data;
   force_type force_data;

   // register writes
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= '0;
         axis_ff.x    <= '0;
         axis_ff.y    <= AxisYReset;
         axis_ff.z    <= '0;
         magnitude_ff <= MagnitudeReset;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_CENTER_X:  center_ff.x  <= csr_ch.data;
            CSR_CENTER_Y:  center_ff.y  <= csr_ch.data;
            CSR_CENTER_Z:  center_ff.z  <= csr_ch.data;
            CSR_AXIS_X:    axis_ff.x    <= csr_ch.data[AxisW-1:0];
            CSR_AXIS_Y:    axis_ff.y    <= csr_ch.data[AxisW-1:0];
            CSR_AXIS_Z:    axis_ff.z    <= csr_ch.data[AxisW-1:0];
            CSR_MAGNITUDE: magnitude_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign req_pos.x = req_ch.pos_x;
   assign req_pos.y = req_ch.pos_y;
   assign req_pos.z = req_ch.pos_z;

   vfv_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_pos    (req_pos),
      .center    (center_ff),
      .axis      (axis_ff),
      .out_valid (cross_valid),
      .out_ready (cross_ready),
      .out_data  (cross_data)
   );

   vfv_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cross_valid),
      .in_ready  (cross_ready),
      .in_data   (cross_data),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_data  (sq_data)
   );

   vfv_root u_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_data   (sq_data),
      .out_valid (unit_valid),
      .out_ready (unit_ready),
      .out_data  (unit_data)
   );

   vfv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unit_valid),
      .in_ready  (unit_ready),
      .in_data   (unit_data),
      .magnitude (magnitude_ff),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (force_data)
   );

   assign rsp_ch.force_x = force_data.x;
   assign rsp_ch.force_y = force_data.y;
   assign rsp_ch.force_z = force_data.z;
   assign rsp_ch.on_axis = force_data.on_axis;

`ifndef ASSERT_OFF
   // pipeline comes out of reset empty
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   // an on-axis particle carries no force
   a_on_axis_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.on_axis |->
         rsp_ch.force_x == '0 && rsp_ch.force_y == '0 && rsp_ch.force_z == '0)
      else $error("nonzero force on axis");

   // zero strength gives zero force whatever the geometry
   a_zero_magnitude: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && magnitude_ff == '0 |->
         rsp_ch.force_x == '0 && rsp_ch.force_y == '0 && rsp_ch.force_z == '0)
      else $error("nonzero force at zero magnitude");
`endif

endmodule

FILE: verif/vortex_force_vector_test.sv
// ----------------------------------------------------------------------------
// vortex_force_vector_test: self-checking bench for the vortex force block
// Drives particle positions under several register settings. An internal
// model predicts each force and the on-axis flag, and every response is
// checked in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module vortex_force_vector_test;
   import vfv_pkg::*;

   localparam logic [CsrIdxW-1:0] CsrUnused = 3'd7;  // no register behind it
   localparam int ItemsRandom = 1600;
   localparam int Phases      = 8;
   localparam int DrainCycles = 40;
   localparam int CycleLimit  = 400000;

   logic clock;
   logic reset;

   vfv_req_if req_ch();
   vfv_rsp_if rsp_ch();
   vfv_csr_if csr_ch();

   vortex_force_vector DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // register shadow
   vec_type                 center;
   axis_type                axis;
   logic signed [MagW-1:0]  magnitude;

   force_type force_queue[$];
   int        fail_count;
   bit        calm;
   int        cycle_count;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL vortex_force_vector");
         $finish;
      end
   end

   // response stall
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   // largest q in [0, 32768] with q^2 * S <= c^2 * 2^30
   function automatic longint unit_root(longint ac, logic [255:0] sumsq);
      logic [255:0] tgt;
      logic [255:0] lhs;
      logic [255:0] t;
      longint       q;
      tgt = 256'(ac) * 256'(ac);
      tgt = tgt << TgtSh;
      q = 0;
      for (int b = UnitW - 1; b >= 0; b--) begin
         t = 256'(q | (longint'(1) << b));
         lhs = t * t * sumsq;
         if (lhs <= tgt)
            q = longint'(t);
      end
      return q;
   endfunction

   // magnitude times unit component, truncated and saturated
   function automatic logic signed [CoordW-1:0] scale_comp(longint c, logic [255:0] sumsq);
      longint u;
      longint p;
      longint f;
      u = unit_root(c < 0 ? -c : c, sumsq);
      if (c < 0)
         u = -u;
      p = longint'(magnitude) * u;
      f = (p < 0) ? -((-p) >>> FracSh) : (p >>> FracSh);
      if (f > 64'sd2147483647)
         f = 64'sd2147483647;
      if (f < -64'sd2147483648)
         f = -64'sd2147483648;
      return f[CoordW-1:0];
   endfunction

   function automatic force_type predict_force(vec_type pos);
      longint       dx, dy, dz, ax, ay, az, cx, cy, cz;
      logic [255:0] sumsq;
      force_type    f;
      dx = longint'(center.x) - longint'(pos.x);
      dy = longint'(center.y) - longint'(pos.y);
      dz = longint'(center.z) - longint'(pos.z);
      ax = longint'(axis.x);
      ay = longint'(axis.y);
      az = longint'(axis.z);
      cx = dy * az - dz * ay;
      cy = dz * ax - dx * az;
      cz = dx * ay - dy * ax;
      if (cx == 0 && cy == 0 && cz == 0) begin
         f = '0;
         f.on_axis = 1'b1;
         return f;
      end
      sumsq = 256'(cx < 0 ? -cx : cx) * 256'(cx < 0 ? -cx : cx)
            + 256'(cy < 0 ? -cy : cy) * 256'(cy < 0 ? -cy : cy)
            + 256'(cz < 0 ? -cz : cz) * 256'(cz < 0 ? -cz : cz);
      f.x = scale_comp(cx, sumsq);
      f.y = scale_comp(cy, sumsq);
      f.z = scale_comp(cz, sumsq);
      f.on_axis = 1'b0;
      return f;
   endfunction

   // ------------------------------------------------------------------------
   // response check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      force_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (force_queue.size() == 0) begin
            $error("response with no transaction outstanding");
            fail_count++;
         end else begin
            want = force_queue.pop_front();
            if (rsp_ch.force_x !== want.x) begin
               $error("force_x expected %0d actual %0d", want.x, rsp_ch.force_x);
               fail_count++;
            end
            if (rsp_ch.force_y !== want.y) begin
               $error("force_y expected %0d actual %0d", want.y, rsp_ch.force_y);
               fail_count++;
            end
            if (rsp_ch.force_z !== want.z) begin
               $error("force_z expected %0d actual %0d", want.z, rsp_ch.force_z);
               fail_count++;
            end
            if (rsp_ch.on_axis !== want.on_axis) begin
               $error("on_axis expected %0b actual %0b", want.on_axis, rsp_ch.on_axis);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers (entered and left at a rising edge)
   // ------------------------------------------------------------------------
   task automatic send_particle(vec_type pos);
      while (!calm && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pos_x <= pos.x;
      req_ch.pos_y <= pos.y;
      req_ch.pos_z <= pos.z;
      do
         @(posedge clock);
      while (!(req_ch.valid && req_ch.ready));
      force_queue.push_back(predict_force(pos));
   endtask

   task automatic send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vec_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      send_particle(p);
   endtask

   // waits out every outstanding transaction; with settle set it then also idles past the pipeline depth
   task automatic drain(bit settle);
      req_ch.valid <= 1'b0;
      while (force_queue.size() != 0)
         @(posedge clock);
      if (settle)
         repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [31:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do
         @(posedge clock);
      while (!(csr_ch.valid && csr_ch.ready));
      // valid drops between register writes
      csr_ch.valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_CENTER_X:  center.x  = data;
         CSR_CENTER_Y:  center.y  = data;
         CSR_CENTER_Z:  center.z  = data;
         CSR_AXIS_X:    axis.x    = data[AxisW-1:0];
         CSR_AXIS_Y:    axis.y    = data[AxisW-1:0];
         CSR_AXIS_Z:    axis.z    = data[AxisW-1:0];
         CSR_MAGNITUDE: magnitude = data;
         default: ;
      endcase
   endtask

   task automatic set_all(vec_type c, axis_type a, logic [31:0] m);
      write_csr(CSR_CENTER_X, c.x);
      write_csr(CSR_CENTER_Y, c.y);
      write_csr(CSR_CENTER_Z, c.z);
      write_csr(CSR_AXIS_X, 32'(a.x));
      write_csr(CSR_AXIS_Y, 32'(a.y));
      write_csr(CSR_AXIS_Z, 32'(a.z));
      write_csr(CSR_MAGNITUDE, m);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(4000)) - 2000) <<< 16;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(6))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'h4000;
         default: return 16'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset values: axis along y, unit magnitude
   task automatic test_reset_values();
      send_xyz(32'h0, 32'h0, 32'h0);                 // at the center
      send_xyz(32'h0, 32'h7fff_ffff, 32'h0);         // on the axis line
      send_xyz(32'h0001_0000, 32'h0, 32'h0);
      send_xyz(32'h0, 32'h0, 32'hffff_0000);
      send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_xyz(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_xyz(32'h8000_0000, 32'h0, 32'h7fff_ffff);
      send_xyz(32'h0000_0001, 32'h1234_5678, 32'hffff_ffff);
      drain(1);
   endtask

   // full-scale unit component with the most negative magnitude saturates
   task automatic test_saturation();
      vec_type  c;
      axis_type a;
      c = '0;
      a = '{x: 16'sd0, y: 16'sd16384, z: 16'sd0};
      set_all(c, a, 32'h8000_0000);
      write_csr(CsrUnused, 32'hdead_beef);
      send_xyz(32'h0001_0000, 32'h0, 32'h0);
      send_xyz(32'hffff_0000, 32'h0, 32'h0);
      send_xyz(32'h0, 32'h0, 32'h0001_0000);
      send_xyz(32'h0, 32'h0005_0000, 32'h0);         // on the axis
      drain(1);
   endtask

   // extreme center and axis, zero axis
   task automatic test_extremes();
      vec_type  c;
      axis_type a;
      c = '{x: 32'h7fff_ffff, y: 32'h8000_0000, z: 32'h7fff_ffff};
      a = '{x: 16'h8000, y: 16'h7fff, z: 16'h8000};
      set_all(c, a, 32'h7fff_ffff);
      send_xyz(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_xyz(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      send_xyz(32'h0, 32'h0, 32'h0);
      send_xyz(32'hffff_ffff, 32'h1, 32'h8000_0001);
      drain(1);
      a = '0;
      set_all(c, a, 32'h0001_0000);
      send_xyz(32'h1234_5678, 32'h8765_4321, 32'h0);
      drain(1);
   endtask

   task automatic test_random_phases();
      vec_type     c, p;
      axis_type    a;
      int          per_phase;
      longint      t;
      per_phase = ItemsRandom / Phases;
      for (int ph = 0; ph < Phases; ph++) begin
         c.x = pick_word();
         c.y = pick_word();
         c.z = pick_word();
         a.x = pick_axis();
         a.y = pick_axis();
         a.z = pick_axis();
         set_all(c, a, pick_word());
         calm = (ph == 3);
         for (int i = 0; i < per_phase; i++) begin
            case ($urandom_range(9))
               0, 1: begin
                  // on the axis line through the center
                  t = longint'($urandom_range(200)) - 100;
                  p.x = 32'(longint'(c.x) - t * longint'(a.x));
                  p.y = 32'(longint'(c.y) - t * longint'(a.y));
                  p.z = 32'(longint'(c.z) - t * longint'(a.z));
               end
               2, 3: begin
                  // near the center
                  p.x = c.x + 32'($signed($urandom_range(2000)) - 1000);
                  p.y = c.y + 32'($signed($urandom_range(2000)) - 1000);
                  p.z = c.z + 32'($signed($urandom_range(2000)) - 1000);
               end
               default: begin
                  p.x = $urandom;
                  p.y = $urandom;
                  p.z = $urandom;
               end
            endcase
            send_particle(p);
            if (ph == 5 && i == per_phase / 2)
               drain(0);
         end
         calm = 1'b0;
         drain(1);
      end
   endtask

   initial begin
      fail_count   = 0;
      cycle_count  = 0;
      calm         = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.pos_z = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_CENTER_X;
      csr_ch.data  = '0;
      center       = '0;
      axis         = '{x: 16'sd0, y: AxisYReset, z: 16'sd0};
      magnitude    = MagnitudeReset;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_saturation();
      test_extremes();
      test_random_phases();

      drain(1);
      if (fail_count == 0)
         $display("PASS vortex_force_vector");
      else
         $display("FAIL vortex_force_vector");
      $finish;
   end

endmodule
